/* hdl/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, constants and helper functions for the world to screen
// projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_COEFS     = 12;
  localparam int unsigned COEF_IDX_W    = 4;
  localparam int unsigned DIM_W         = 14;
  localparam int unsigned DIV_STEPS     = 31;
  localparam int unsigned S_TDATA_W     = 136;
  localparam int unsigned M_TDATA_W     = 64;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

  // One stage of the shared restoring divider, carrying both x and y.
  typedef struct packed {
    logic        front;
    logic        negx;
    logic        negy;
    logic        ovfx;
    logic        ovfy;
    logic [63:0] d;
    logic [63:0] rx;
    logic [63:0] ry;
    logic [30:0] nbx;
    logic [30:0] nby;
    logic [30:0] qx;
    logic [30:0] qy;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [63:0] tx;
    logic [63:0] ty;
    o  = s;
    tx = {s.rx[62:0], s.nbx[30]};
    ty = {s.ry[62:0], s.nby[30]};
    if (tx >= s.d) begin
      o.rx = tx - s.d;
      o.qx = {s.qx[29:0], 1'b1};
    end else begin
      o.rx = tx;
      o.qx = {s.qx[29:0], 1'b0};
    end
    if (ty >= s.d) begin
      o.ry = ty - s.d;
      o.qy = {s.qy[29:0], 1'b1};
    end else begin
      o.ry = ty;
      o.qy = {s.qy[29:0], 1'b0};
    end
    o.nbx = {s.nbx[29:0], 1'b0};
    o.nby = {s.nby[29:0], 1'b0};
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] ndc_of(logic neg, logic ovf, logic [30:0] q);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg) begin
      r = -$signed({1'b0, q});
    end else begin
      r = $signed({1'b0, q});
    end
    return r;
  endfunction

endpackage

/* hdl/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Loads a 3x4 world-to-clip coefficient table and projects world points to
// viewport pixel positions in signed fixed point, one point per cycle while the output is not stalled.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  s_tuser operation, s_tdata point
//   m_*       out        m_tvalid / m_tready  m_tuser in_front, m_tdata screen
//   cfg_*     in         cfg_we               cfg_index, cfg_data
//
// A word is accepted every cycle while the pipeline has room.
// A projection reaches the output register through a pipeline whose depth is
// set by the 31 steps of the pipelined divider.
// A load word produces no result and affects every projection accepted after it.
// A stall holds only the stages behind a full stage, so bubbles close up.
// Reset clears the coefficient table and the valid bits and sets the viewport size to 1920 by 1080.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
  parameter int unsigned FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // coef_index, coef_value, point_x, point_y, point_z, zero fill
  input  logic [wsp_pkg::S_TDATA_W-1:0] s_tdata,
  // operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // screen_x, screen_y
  output logic [wsp_pkg::M_TDATA_W-1:0] m_tdata,
  // in_front
  output logic                          m_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [wsp_pkg::DIM_W-1:0]     cfg_data
);
  import wsp_pkg::*;

  localparam longint THR       = ((longint'(1) << FRAC_BITS) + 999) / 1000;
  localparam int     ST_IN     = 0;
  localparam int     ST_PROD   = 1;
  localparam int     ST_PAIR   = 2;
  localparam int     ST_CLIP   = 3;
  localparam int     ST_MAG    = 4;
  localparam int     ST_DIV0   = 5;
  localparam int     ST_NDC    = ST_DIV0 + DIV_STEPS + 1;
  localparam int     ST_MUL    = ST_NDC + 1;
  localparam int     ST_HALF   = ST_MUL + 1;
  localparam int     ST_OUT    = ST_HALF + 1;
  localparam int     NS        = ST_OUT + 1;

  logic [DIM_W-1:0]        screen_width;
  logic [DIM_W-1:0]        screen_height;
  logic signed [31:0]      coef_tbl [NUM_COEFS];

  logic [NS-1:0]           v;
  logic [NS-1:0]           en;

  logic                    op0;
  logic [COEF_IDX_W-1:0]   idx0;
  logic signed [31:0]      coef0;
  logic signed [31:0]      pt0 [3];

  logic signed [63:0]      prod [3][3];
  logic signed [31:0]      cst  [3];
  logic signed [63:0]      pa   [3];
  logic signed [63:0]      pb   [3];
  logic signed [63:0]      clip [3];

  logic                    front4;
  logic                    negx4;
  logic                    negy4;
  logic [63:0]             magx4;
  logic [63:0]             magy4;
  logic [63:0]             d4;

  div_t                    dv [DIV_STEPS+1];

  logic                    front_n;
  logic signed [31:0]      ndcx;
  logic signed [31:0]      ndcy;
  logic                    front_m;
  logic signed [46:0]      mulx;
  logic signed [46:0]      muly;
  logic                    front_h;
  logic signed [47:0]      hrx;
  logic signed [47:0]      hry;
  logic signed [47:0]      basex;
  logic signed [47:0]      basey;
  logic                    front_o;
  logic signed [31:0]      sx;
  logic signed [31:0]      sy;

  logic [63:0]             rx_init;
  logic [63:0]             ry_init;

  assign s_tready = en[ST_IN];
  assign m_tvalid = v[ST_OUT];
  assign m_tuser  = front_o;
  assign m_tdata  = {sy, sx};

  assign rx_init = magx4 >> (31 - FRAC_BITS);
  assign ry_init = magy4 >> (31 - FRAC_BITS);

  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default:           screen_width  <= screen_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_tbl[i] <= '0;
      end
    end else if (en[ST_PROD] && v[ST_IN] && op0 == OP_LOAD &&
                 idx0 < COEF_IDX_W'(NUM_COEFS)) begin
      coef_tbl[idx0] <= coef0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[ST_IN]) begin
        v[ST_IN] <= s_tvalid;
      end
      if (en[ST_PROD]) begin
        v[ST_PROD] <= v[ST_IN] && op0 == OP_PROJECT;
      end
      for (int k = ST_PAIR; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      op0    <= s_tuser;
      idx0   <= s_tdata[3:0];
      coef0  <= s_tdata[35:4];
      pt0[0] <= s_tdata[67:36];
      pt0[1] <= s_tdata[99:68];
      pt0[2] <= s_tdata[131:100];
    end

    if (en[ST_PROD]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= 64'(coef_tbl[r*4+c]) * 64'(pt0[c]);
        end
        cst[r] <= coef_tbl[r*4+3];
      end
    end

    if (en[ST_PAIR]) begin
      for (int r = 0; r < 3; r++) begin
        pa[r] <= (prod[r][0] >>> FRAC_BITS) + (prod[r][1] >>> FRAC_BITS);
        pb[r] <= (prod[r][2] >>> FRAC_BITS) + 64'(cst[r]);
      end
    end

    if (en[ST_CLIP]) begin
      for (int r = 0; r < 3; r++) begin
        clip[r] <= pa[r] + pb[r];
      end
    end

    if (en[ST_MAG]) begin
      front4 <= clip[2] >= THR;
      negx4  <= clip[0][63];
      negy4  <= clip[1][63];
      magx4  <= clip[0][63] ? 64'(-clip[0]) : 64'(clip[0]);
      magy4  <= clip[1][63] ? 64'(-clip[1]) : 64'(clip[1]);
      d4     <= 64'(clip[2]);
    end

    if (en[ST_DIV0]) begin
      dv[0].front <= front4;
      dv[0].negx  <= negx4;
      dv[0].negy  <= negy4;
      dv[0].d     <= d4;
      dv[0].rx    <= rx_init;
      dv[0].ry    <= ry_init;
      dv[0].ovfx  <= rx_init >= d4;
      dv[0].ovfy  <= ry_init >= d4;
      dv[0].nbx   <= 31'(magx4 << FRAC_BITS);
      dv[0].nby   <= 31'(magy4 << FRAC_BITS);
      dv[0].qx    <= '0;
      dv[0].qy    <= '0;
    end

    for (int i = 1; i <= DIV_STEPS; i++) begin
      if (en[ST_DIV0+i]) begin
        dv[i] <= div_step(dv[i-1]);
      end
    end

    if (en[ST_NDC]) begin
      front_n <= dv[DIV_STEPS].front;
      ndcx    <= ndc_of(dv[DIV_STEPS].negx, dv[DIV_STEPS].ovfx, dv[DIV_STEPS].qx);
      ndcy    <= ndc_of(dv[DIV_STEPS].negy, dv[DIV_STEPS].ovfy, dv[DIV_STEPS].qy);
    end

    if (en[ST_MUL]) begin
      front_m <= front_n;
      mulx    <= 47'(ndcx) * 47'($signed({1'b0, screen_width}));
      muly    <= 47'(ndcy) * 47'($signed({1'b0, screen_height}));
    end

    if (en[ST_HALF]) begin
      front_h <= front_m;
      hrx     <= (48'(mulx) + (48'sd1 <<< FRAC_BITS)) >>> 1;
      hry     <= (48'(muly) + (48'sd1 <<< FRAC_BITS)) >>> 1;
      basex   <= $signed(48'(screen_width >> 1) << FRAC_BITS);
      basey   <= $signed(48'(screen_height >> 1) << FRAC_BITS);
    end

    if (en[ST_OUT]) begin
      front_o <= front_h;
      sx      <= front_h ? sat32(basex + hrx) : '0;
      sy      <= front_h ? sat32(basey - hry) : '0;
    end
  end

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("Point behind the camera has nonzero screen coordinates.");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled although the output register is empty.");

  a_div_rem_x: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIV0+DIV_STEPS] && dv[DIV_STEPS].front && !dv[DIV_STEPS].ovfx |->
      dv[DIV_STEPS].rx < dv[DIV_STEPS].d)
    else $error("Divider x remainder is not below the divisor.");

  a_div_rem_y: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIV0+DIV_STEPS] && dv[DIV_STEPS].front && !dv[DIV_STEPS].ovfy |->
      dv[DIV_STEPS].ry < dv[DIV_STEPS].d)
    else $error("Divider y remainder is not below the divisor.");

endmodule

/* tb/world_to_screen_projection_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_tb
// Self-checking bench for the point projection pipeline. Coefficient loads
// and point words are streamed in random bursts while the output side stalls
// on its own pattern. A scoreboard keeps its own copy of the coefficient table
// and viewport size and predicts every projected word. The predictions are
// checked field by field in order. The viewport is rewritten between phases,
// including the extremes of both registers.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb;

  localparam int FRAC = wsp_pkg::FRAC_BITS_DEF;
  localparam longint W_MIN = ((longint'(1) << FRAC) + 999) / 1000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  typedef struct {
    logic               in_front;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } screen_pos_t;

  class projection_scoreboard;
    logic signed [31:0]       coefs [wsp_pkg::NUM_COEFS];
    logic [wsp_pkg::DIM_W-1:0] width_px;
    logic [wsp_pkg::DIM_W-1:0] height_px;
    screen_pos_t              pending_pos [$];
    int                       errors;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      width_px  = wsp_pkg::SCREEN_WIDTH_RST;
      height_px = wsp_pkg::SCREEN_HEIGHT_RST;
      errors    = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function longint clip_row(int row, longint px, longint py, longint pz);
      longint acc;
      acc = longint'(coefs[row*4+3]);
      acc += (longint'(coefs[row*4]) * px) >>> FRAC;
      acc += (longint'(coefs[row*4+1]) * py) >>> FRAC;
      acc += (longint'(coefs[row*4+2]) * pz) >>> FRAC;
      return acc;
    endfunction

    function longint clip_to_ndc(longint num, longint den);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] quo;
      neg = num < 0;
      mag = {64'b0, neg ? -num : num};
      quo = (mag << FRAC) / {64'b0, den};
      if (quo >= 128'h8000_0000) return neg ? -longint'(32'h8000_0000) : longint'(MAXV);
      return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function longint half_span(longint ndc, logic [wsp_pkg::DIM_W-1:0] span);
      return (ndc * longint'(span) + (longint'(1) << FRAC)) >>> 1;
    endfunction

    function logic signed [31:0] clamp_word(longint v);
      if (v > longint'(MAXV)) return MAXV;
      if (v < longint'(MINV)) return MINV;
      return v[31:0];
    endfunction

    function screen_pos_t project_point(longint px, longint py, longint pz);
      screen_pos_t r;
      longint      cx;
      longint      cy;
      longint      cw;
      longint      sx;
      longint      sy;
      cx = clip_row(0, px, py, pz);
      cy = clip_row(1, px, py, pz);
      cw = clip_row(2, px, py, pz);
      r.in_front = 1'b0;
      r.x = '0;
      r.y = '0;
      if (cw < W_MIN) return r;
      sx = (longint'(width_px >> 1) << FRAC) + half_span(clip_to_ndc(cx, cw), width_px);
      sy = (longint'(height_px >> 1) << FRAC) - half_span(clip_to_ndc(cy, cw), height_px);
      r.in_front = 1'b1;
      r.x = clamp_word(sx);
      r.y = clamp_word(sy);
      return r;
    endfunction

    function void note_word(logic op, logic [wsp_pkg::S_TDATA_W-1:0] d);
      if (op == wsp_pkg::OP_LOAD) begin
        if (d[3:0] < wsp_pkg::NUM_COEFS) coefs[d[3:0]] = d[35:4];
      end else begin
        pending_pos.push_back(project_point(longint'($signed(d[67:36])),
                                            longint'($signed(d[99:68])),
                                            longint'($signed(d[131:100]))));
      end
    endfunction

    task check_word(logic front, logic [wsp_pkg::M_TDATA_W-1:0] d);
      screen_pos_t want;
      if (pending_pos.size() == 0) begin
        report_mismatch($sformatf("unexpected word front=%0b x=%0d y=%0d",
                                  front, $signed(d[31:0]), $signed(d[63:32])));
      end else begin
        want = pending_pos.pop_front();
        if (front !== want.in_front)
          report_mismatch($sformatf("in_front got %0b want %0b", front, want.in_front));
        if ($signed(d[31:0]) !== want.x)
          report_mismatch($sformatf("screen_x got %0d want %0d", $signed(d[31:0]), want.x));
        if ($signed(d[63:32]) !== want.y)
          report_mismatch($sformatf("screen_y got %0d want %0d", $signed(d[63:32]), want.y));
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [wsp_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [wsp_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [wsp_pkg::DIM_W-1:0]     cfg_data;

  projection_scoreboard sb;
  bit                   hold_req = 1'b0;
  int                   burst_left = 0;

  world_to_screen_projection DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata);
  end

  task automatic send_word(input logic op, input logic [wsp_pkg::S_TDATA_W-1:0] d);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_load(input logic [3:0] slot, input logic signed [31:0] v);
    send_word(wsp_pkg::OP_LOAD, {100'b0, v, slot});
  endtask

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    send_word(wsp_pkg::OP_PROJECT, {4'b0, z, y, x, $urandom, 4'($urandom_range(0, 15))});
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_pos.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_viewport(input logic [wsp_pkg::DIM_W-1:0] w,
                                input logic [wsp_pkg::DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= wsp_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= wsp_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.width_px  = w;
    sb.height_px = h;
  endtask

  function automatic logic signed [31:0] rand_near(int r);
    int v;
    v = int'($urandom_range(0, 2 * r)) - r;
    return v;
  endfunction

  function automatic logic signed [31:0] rand_extreme();
    case ($urandom_range(0, 3))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      default: return ONE;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return rand_near(32'h0010_0000);
      6, 7: return $urandom;
      8: return rand_extreme();
      default: return 60 + $urandom_range(0, 10);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return rand_extreme();
      default: return rand_near(32'h0004_0000);
    endcase
  endfunction

  // A usable camera: w is close to z, x and y rows are modest scales and offsets.
  task automatic load_matrix();
    logic signed [31:0] v;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == 2) v = (c == 2) ? ONE + rand_near(4096) : rand_near(4096);
        else v = (c == r) ? rand_near(32'h0002_0000) : rand_near(32'h8000);
        send_load(4'(r * 4 + c), v);
        pace();
      end
    end
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 12) send_load(4'($urandom_range(0, 15)), rand_coef());
    else send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    int                       mode;
    int                       t;
    m_tready <= 1'b0;
    mode = 0;
    t = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (t % 40 == 0) mode = $urandom_range(0, 2);
        t++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (t % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    logic [wsp_pkg::DIM_W-1:0] vp_w [5];
    logic [wsp_pkg::DIM_W-1:0] vp_h [5];
    sb = new();
    vp_w = '{14'd1, 14'd8192, 14'd0, 14'd16383, 14'($urandom_range(1, 8192))};
    vp_h = '{14'd8192, 14'd1, 14'd16383, 14'd0, 14'($urandom_range(1, 8192))};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= wsp_pkg::OP_LOAD;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= wsp_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With an empty table w is zero, so the point lies behind the camera.
    send_point(ONE, ONE, ONE);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_load(4'(r * 4 + c), (c == ((r == 2) ? 2 : r)) ? ONE : '0);
      end
    end
    send_load(4'd12, MAXV);
    send_load(4'd15, MINV);
    send_point('0, '0, ONE);
    send_point(ONE, ONE, 32'(W_MIN));
    send_point(ONE, ONE, 32'(W_MIN - 1));
    send_point(ONE, -ONE, -ONE);
    send_point(MAXV, MINV, ONE);
    send_point(MINV, MAXV, 32'(W_MIN));
    send_point(ONE >>> 1, -(ONE >>> 1), ONE);
    send_point(MAXV, MAXV, MAXV);
    send_point(MINV, MINV, MINV);

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p > 0) write_viewport(vp_w[p-1], vp_h[p-1]);
      load_matrix();
      for (int i = 0; i < 75; i++) begin
        if (p == 2 && i == 0) hold_req = 1'b1;
        random_item();
        if (p != 2 || i >= 60) pace();
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
